// ----- rtl/icc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// icc_pkg: shared types and constants for the IR climate command codec
// Payload structs, climate state, mode codes, fixed command words and the
// temperature code map.
// ----------------------------------------------------------------------------
package icc_pkg;

    typedef struct packed {
        logic        req_type;
        logic [23:0] rx_code;
        logic [2:0]  set_mode;
        logic [1:0]  set_fan;
        logic [6:0]  set_temp_half;
        logic        swing_present;
        logic        set_swing;
    } icc_in_t;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  out_mode;
        logic [1:0]  out_fan;
        logic [1:0]  out_preset;
        logic        out_swing;
        logic [6:0]  out_temp_half;
        logic [23:0] tx_code;
        logic        tx_valid;
    } icc_out_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] fan;
        logic [1:0] preset;
        logic       swing;
        logic [6:0] temp_half;
    } icc_state_t;

    typedef struct packed {
        logic [5:0] min_temp;
        logic [5:0] max_temp;
    } icc_cfg_t;

    localparam logic [2:0] MODE_OFF  = 3'd0;
    localparam logic [2:0] MODE_COOL = 3'd1;
    localparam logic [2:0] MODE_HEAT = 3'd2;
    localparam logic [2:0] MODE_AUTO = 3'd3;
    localparam logic [2:0] MODE_DRY  = 3'd4;
    localparam logic [2:0] MODE_FAN  = 3'd5;

    localparam logic [1:0] FAN_AUTO = 2'd0;
    localparam logic [1:0] FAN_LOW  = 2'd1;
    localparam logic [1:0] FAN_MED  = 2'd2;
    localparam logic [1:0] FAN_HIGH = 2'd3;

    localparam logic [1:0] PRESET_NONE  = 2'd0;
    localparam logic [1:0] PRESET_SLEEP = 2'd1;
    localparam logic [1:0] PRESET_BOOST = 2'd2;

    localparam logic [23:0] WORD_BASE  = 24'hB20F00;
    localparam logic [23:0] WORD_OFF   = 24'hB27BE0;
    localparam logic [23:0] WORD_SWING = 24'hB26BE0;
    localparam logic [23:0] WORD_SLEEP = 24'hB2E003;
    localparam logic [23:0] WORD_TURBO = 24'hB5F5A2;

    localparam logic [7:0] HDR_MAIN = 8'hB2;
    localparam logic [7:0] HDR_ALT  = 8'hB5;

    localparam logic [0:0] CFG_MIN_TEMP = 1'b0;
    localparam logic [0:0] CFG_MAX_TEMP = 1'b1;

    localparam logic [6:0]  TEMP_HALF_RESET = 7'd50;
    localparam logic [5:0]  MIN_TEMP_RESET  = 6'd17;
    localparam logic [5:0]  MAX_TEMP_RESET  = 6'd30;
    localparam logic [3:0]  TEMP_IDX_MAX    = 4'd13;

    function automatic logic [7:0] temp_code(input logic [3:0] idx);
        logic [7:0] code;
        case (idx)
            4'd0:    code = 8'h00;
            4'd1:    code = 8'h10;
            4'd2:    code = 8'h30;
            4'd3:    code = 8'h20;
            4'd4:    code = 8'h60;
            4'd5:    code = 8'h70;
            4'd6:    code = 8'h50;
            4'd7:    code = 8'h40;
            4'd8:    code = 8'hC0;
            4'd9:    code = 8'hD0;
            4'd10:   code = 8'h90;
            4'd11:   code = 8'h80;
            4'd12:   code = 8'hA0;
            4'd13:   code = 8'hB0;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/icc_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// icc_step: next-state and result logic for one transaction
// Decodes a received word or encodes a user command against the current
// climate state and the temperature limits.
// ----------------------------------------------------------------------------
module icc_step
    import icc_pkg::*;
(
    input  wire icc_in_t    req,
    input  wire icc_state_t cur,
    input  wire icc_cfg_t   cfg,
    output icc_state_t      nxt,
    output icc_out_t        res
);

    logic        acc;
    logic        txv;
    logic [23:0] tx;
    logic [23:0] w;
    logic [7:0]  hdr;
    logic [3:0]  dec_idx;
    logic        dec_hit;
    logic [6:0]  dec_sum;
    logic [7:0]  dec_half;
    logic [6:0]  lo;
    logic [6:0]  hi;
    logic [6:0]  t;
    logic [7:0]  t_inc;
    logic [6:0]  deg;
    logic [6:0]  diff;
    logic [3:0]  enc_idx;

    always_comb begin
        case ({req.rx_code[7:4], 4'h0})
            8'h00:   begin dec_hit = 1'b1; dec_idx = 4'd0;  end
            8'h10:   begin dec_hit = 1'b1; dec_idx = 4'd1;  end
            8'h30:   begin dec_hit = 1'b1; dec_idx = 4'd2;  end
            8'h20:   begin dec_hit = 1'b1; dec_idx = 4'd3;  end
            8'h60:   begin dec_hit = 1'b1; dec_idx = 4'd4;  end
            8'h70:   begin dec_hit = 1'b1; dec_idx = 4'd5;  end
            8'h50:   begin dec_hit = 1'b1; dec_idx = 4'd6;  end
            8'h40:   begin dec_hit = 1'b1; dec_idx = 4'd7;  end
            8'hC0:   begin dec_hit = 1'b1; dec_idx = 4'd8;  end
            8'hD0:   begin dec_hit = 1'b1; dec_idx = 4'd9;  end
            8'h90:   begin dec_hit = 1'b1; dec_idx = 4'd10; end
            8'h80:   begin dec_hit = 1'b1; dec_idx = 4'd11; end
            8'hA0:   begin dec_hit = 1'b1; dec_idx = 4'd12; end
            8'hB0:   begin dec_hit = 1'b1; dec_idx = 4'd13; end
            default: begin dec_hit = 1'b0; dec_idx = 4'd0;  end
        endcase
        dec_sum  = {3'd0, dec_idx} + {1'b0, cfg.min_temp};
        dec_half = {dec_sum, 1'b0};
    end

    // clamp, round half up, map to index
    always_comb begin
        lo = {cfg.min_temp, 1'b0};
        hi = {cfg.max_temp, 1'b0};
        t  = req.set_temp_half;
        if (t < lo) begin
            t = lo;
        end
        if (t > hi) begin
            t = hi;
        end
        t_inc = {1'b0, t} + 8'd1;
        deg   = t_inc[7:1];
        diff  = deg - {1'b0, cfg.min_temp};
        if (deg < {1'b0, cfg.min_temp}) begin
            enc_idx = 4'd0;
        end else if (diff > {3'd0, TEMP_IDX_MAX}) begin
            enc_idx = TEMP_IDX_MAX;
        end else begin
            enc_idx = diff[3:0];
        end
    end

    always_comb begin
        nxt = cur;
        acc = 1'b0;
        txv = 1'b0;
        tx  = '0;
        w   = WORD_BASE;
        hdr = req.rx_code[23:16];
        if (!req.req_type) begin
            if (hdr == HDR_MAIN || hdr == HDR_ALT) begin
                acc = 1'b1;
                if (req.rx_code == WORD_OFF) begin
                    nxt.mode   = MODE_OFF;
                    nxt.preset = PRESET_NONE;
                end else if (req.rx_code == WORD_SWING) begin
                    nxt.swing = ~cur.swing;
                end else if (req.rx_code == WORD_SLEEP) begin
                    if (cur.mode != MODE_DRY && cur.mode != MODE_FAN) begin
                        nxt.preset = PRESET_SLEEP;
                        nxt.fan    = FAN_AUTO;
                    end
                end else if (req.rx_code == WORD_TURBO) begin
                    if (cur.mode == MODE_COOL || cur.mode == MODE_HEAT) begin
                        nxt.preset = (cur.preset == PRESET_BOOST) ? PRESET_NONE
                                                                  : PRESET_BOOST;
                        nxt.fan    = FAN_AUTO;
                    end
                end else begin
                    case (req.rx_code[3:2])
                        2'b11:   nxt.mode = MODE_HEAT;
                        2'b10:   nxt.mode = MODE_AUTO;
                        2'b01:   nxt.mode = (req.rx_code[15:12] == 4'h1) ? MODE_DRY
                                                                         : MODE_FAN;
                        default: nxt.mode = MODE_COOL;
                    endcase
                    if ((req.rx_code[15:12] & 4'hB) == 4'hB
                        || nxt.mode == MODE_AUTO || nxt.mode == MODE_DRY) begin
                        nxt.fan = FAN_AUTO;
                    end else if ((req.rx_code[15:12] & 4'h9) == 4'h9) begin
                        nxt.fan = FAN_LOW;
                    end else if ((req.rx_code[15:12] & 4'h5) == 4'h5) begin
                        nxt.fan = FAN_MED;
                    end else if ((req.rx_code[15:12] & 4'h3) == 4'h3) begin
                        nxt.fan = FAN_HIGH;
                    end
                    if (dec_hit) begin
                        nxt.temp_half = dec_half[7] ? 7'd127 : dec_half[6:0];
                    end
                end
            end
        end else if (req.set_mode <= MODE_FAN) begin
            acc           = 1'b1;
            txv           = 1'b1;
            nxt.mode      = req.set_mode;
            nxt.fan       = req.set_fan;
            nxt.temp_half = req.set_temp_half;
            if (req.set_mode == MODE_OFF) begin
                nxt.swing = 1'b0;
            end
            if (req.swing_present) begin
                nxt.swing = req.set_swing;
                tx        = WORD_SWING;
            end else if (req.set_mode == MODE_OFF) begin
                tx = WORD_OFF;
            end else begin
                if (req.set_mode == MODE_HEAT) begin
                    w[3:0] = 4'hC;
                end else if (req.set_mode == MODE_AUTO) begin
                    w[3:0] = 4'h8;
                end else if (req.set_mode == MODE_DRY || req.set_mode == MODE_FAN) begin
                    w[3:0] = 4'h4;
                end
                if (req.set_mode != MODE_FAN) begin
                    w[7:0] = w[7:0] | temp_code(enc_idx);
                end else begin
                    w[7:0] = w[7:0] | 8'hE0;
                end
                if (req.set_mode == MODE_AUTO || req.set_mode == MODE_DRY) begin
                    nxt.fan = FAN_AUTO;
                    w[15:12] = 4'h1;
                end else if (req.set_fan == FAN_HIGH) begin
                    w[15:12] = 4'h3;
                end else if (req.set_fan == FAN_MED) begin
                    w[15:12] = 4'h5;
                end else if (req.set_fan == FAN_LOW) begin
                    w[15:12] = 4'h9;
                end else begin
                    w[15:12] = 4'hB;
                end
                tx = w;
            end
        end
    end

    always_comb begin
        res.accepted      = acc;
        res.out_mode      = nxt.mode;
        res.out_fan       = nxt.fan;
        res.out_preset    = nxt.preset;
        res.out_swing     = nxt.swing;
        res.out_temp_half = nxt.temp_half;
        res.tx_code       = tx;
        res.tx_valid      = txv;
    end

endmodule
`default_nettype wire

// ----- rtl/ir_climate_command_codec_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ir_climate_command_codec_core: air-conditioner IR command codec
// Holds the climate state, decodes received 24-bit remote words and encodes
// user commands into the 24-bit word to transmit.
//
// Input channel s_*: one transaction is either a received remote word
// (req_type 0) or a user command (req_type 1). Result channel m_*: exactly
// one result per input transaction, in order, reporting the state after it.
// Configuration port cfg_*: index 0 lowest, index 1 highest temperature in
// degrees; write only while no transaction is in flight.
//
// Path: an accepted input is held in the input register, then the
// decode/encode logic writes the result register, which also updates the
// climate state. Throughput: one transaction per cycle while not stalled.
//
// Reset: state goes to off, fan auto, no preset, swing off, 25 degrees;
// limits go to 17 and 30 degrees; both stages empty.
// Stall: when m_ready is low the result holds, the input register keeps
// one more transaction, and s_ready drops once both are full.
// ----------------------------------------------------------------------------
module ir_climate_command_codec_core
    import icc_pkg::*;
(
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_valid,
    output logic         s_ready,
    input  wire icc_in_t s_data,
    output logic         m_valid,
    input  wire          m_ready,
    output icc_out_t     m_data,
    input  wire          cfg_we,
    input  wire  [0:0]   cfg_index,
    input  wire  [5:0]   cfg_wdata
);

    icc_in_t    in_data_reg;
    logic       in_valid_reg;
    icc_out_t   out_data_reg;
    logic       out_valid_reg;
    icc_state_t state_reg;
    icc_cfg_t   cfg_reg;
    icc_state_t state_next;
    icc_out_t   out_next;
    logic       advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    icc_step u_step (
        .req (in_data_reg),
        .cur (state_reg),
        .cfg (cfg_reg),
        .nxt (state_next),
        .res (out_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode      <= MODE_OFF;
            state_reg.fan       <= FAN_AUTO;
            state_reg.preset    <= PRESET_NONE;
            state_reg.swing     <= 1'b0;
            state_reg.temp_half <= TEMP_HALF_RESET;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_temp <= MIN_TEMP_RESET;
            cfg_reg.max_temp <= MAX_TEMP_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MIN_TEMP: cfg_reg.min_temp <= cfg_wdata;
                CFG_MAX_TEMP: cfg_reg.max_temp <= cfg_wdata;
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    a_tx_implies_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.tx_valid |-> m_data.accepted)
        else $error("word sent for a rejected transaction");

    a_no_word_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.tx_valid |-> m_data.tx_code == 24'd0)
        else $error("tx_code nonzero without tx_valid");

    a_result_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(advance) |-> m_data.out_mode == state_reg.mode
                           && m_data.out_temp_half == state_reg.temp_half)
        else $error("result does not report the updated state");

    a_state_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.mode <= MODE_FAN && state_reg.preset != 2'd3)
        else $error("illegal climate state");

    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("state changed without a transaction");

endmodule
`default_nettype wire
